/* rtl/core/swlp_pkg.sv */
// Shared types and constants for the sliding-window latency percentile tracker.
`timescale 1ns / 1ps
package swlp_pkg;

  localparam int unsigned WINDOW_DEF      = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned LAT_W           = 16;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned HELD_W          = 9;

  typedef struct packed {
    logic [LAT_W-1:0] latency;
    logic             success;
  } in_req_t;

  typedef struct packed {
    logic [LAT_W-1:0]  median_latency;
    logic [LAT_W-1:0]  p95_value;
    logic [LAT_W-1:0]  p99_value;
    logic [CNT_W-1:0]  requests_seen;
    logic [CNT_W-1:0]  successes_seen;
    logic [HELD_W-1:0] samples_held;
  } out_res_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,  // latch request, update counters, read ring slot
    OP_RM_RD    = 4'd2,  // read sorted[idx]
    OP_RM_CMP   = 4'd3,  // compare with victim, step index
    OP_SH_RD    = 4'd4,  // read sorted[idx+1] for left shift
    OP_SH_WR    = 4'd5,  // write sorted[idx], step index
    OP_INS_INIT = 4'd6,  // idx = fill - 1, last slot of the updated window
    OP_INS_RD   = 4'd7,  // read sorted[idx-1]
    OP_INS_STEP = 4'd8,  // shift right or place new value
    OP_PCT_RD   = 4'd9,  // read sorted[pct index]
    OP_PCT_LAT  = 4'd10  // latch percentile, advance selector
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;       // window full at load
    logic rm_hit;     // compared entry equals victim
    logic rm_end;     // index reached last entry
    logic ins_place;  // insertion slot found
  } dp_sts_t;

endpackage

/* rtl/core/swlp_ctrl.sv */
// Controller state machine sequencing remove, insert and percentile reads.
`timescale 1ns / 1ps
module swlp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swlp_pkg::dp_sts_t  sts,
  output swlp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_RMRD  = 10'b0000000100,
    S_RMCMP = 10'b0000001000,
    S_SHRD  = 10'b0000010000,
    S_SHWR  = 10'b0000100000,
    S_INRD  = 10'b0001000000,
    S_INST  = 10'b0010000000,
    S_PRD   = 10'b0100000000,
    S_PLAT  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = swlp_pkg::OP_NONE;
    cmd.sel       = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op    = swlp_pkg::OP_LOAD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.full) begin
          cmd.op    = swlp_pkg::OP_RM_RD;
          state_nxt = S_RMCMP;
        end else begin
          cmd.op    = swlp_pkg::OP_INS_INIT;
          state_nxt = S_INRD;
        end
      end
      S_RMRD: begin
        cmd.op    = swlp_pkg::OP_RM_RD;
        state_nxt = S_RMCMP;
      end
      S_RMCMP: begin
        cmd.op = swlp_pkg::OP_RM_CMP;
        if (sts.rm_hit || sts.rm_end) state_nxt = S_SHRD;
        else state_nxt = S_RMRD;
      end
      S_SHRD: begin
        if (sts.rm_end) begin
          cmd.op    = swlp_pkg::OP_INS_INIT;
          state_nxt = S_INRD;
        end else begin
          cmd.op    = swlp_pkg::OP_SH_RD;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.op    = swlp_pkg::OP_SH_WR;
        state_nxt = S_SHRD;
      end
      S_INRD: begin
        cmd.op    = swlp_pkg::OP_INS_RD;
        state_nxt = S_INST;
      end
      S_INST: begin
        cmd.op = swlp_pkg::OP_INS_STEP;
        if (sts.ins_place) begin
          sel_nxt   = 2'd0;
          state_nxt = S_PRD;
        end else state_nxt = S_INRD;
      end
      S_PRD: begin
        cmd.op    = swlp_pkg::OP_PCT_RD;
        state_nxt = S_PLAT;
      end
      S_PLAT: begin
        cmd.op = swlp_pkg::OP_PCT_LAT;
        if (sel_r == 2'd2) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_PRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLAT && sel_r == 2'd2) |=> out_valid) else $error("result lost");
`endif

endmodule

/* rtl/core/swlp_dp.sv */
// Datapath: age ring, sorted window memory, counters and percentile indices.
`timescale 1ns / 1ps
module swlp_dp #(
  parameter int unsigned WINDOW      = swlp_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swlp_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swlp_pkg::in_req_t  in_data,
  input  logic               out_ready,
  input  swlp_pkg::dp_cmd_t  cmd,
  output swlp_pkg::dp_sts_t  sts,
  output swlp_pkg::out_res_t out_data
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NW = $clog2(WINDOW + 1);
  localparam int unsigned KW = NW + 7;
  localparam int unsigned PW = NW + KW;
  localparam int unsigned CW = swlp_pkg::CNT_W;
  localparam int unsigned LW = swlp_pkg::LAT_W;
  localparam logic [NW-1:0] NFULL = NW'(WINDOW);
  localparam logic [CW-1:0] CMAX = '1;
  // Rounded-up reciprocals q*2^KW/100; exact floor for every n below 2^NW
  localparam longint unsigned KSCALE = 64'd1 << KW;
  localparam logic [KW-1:0] M50 = KW'((KSCALE * 64'd50 + 64'd99) / 64'd100);
  localparam logic [KW-1:0] M95 = KW'((KSCALE * 64'd95 + 64'd99) / 64'd100);
  localparam logic [KW-1:0] M99 = KW'((KSCALE * 64'd99 + 64'd99) / 64'd100);

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] sort_mem [WINDOW];

  logic [SAMPLE_BITS-1:0] lat_r, victim_r, rd_r;
  logic [NW-1:0]          fill_r, idx_r;
  logic [AW-1:0]          oldest_r;
  logic                   full_r;
  logic                   had_full_r;
  logic [CW-1:0]          req_r, suc_r;
  logic [LW-1:0]          p50_r, p95_r, p99_r;

  logic [SAMPLE_BITS-1:0] lat_in;
  logic [NW:0]            wr_sum;
  logic [AW-1:0]          wr_slot;
  logic [AW-1:0]          pct_idx;
  logic [PW-1:0]          prod;
  logic [KW-1:0]          mq;
  logic [NW-1:0]          last_idx;

  generate
    if (SAMPLE_BITS >= LW) begin : g_wide
      assign lat_in = SAMPLE_BITS'(in_data.latency);
    end else begin : g_narrow
      assign lat_in = in_data.latency[SAMPLE_BITS-1:0];
    end
  endgenerate

  // Next free ring slot, wrapped at WINDOW
  assign wr_sum   = (NW+1)'(oldest_r) + (NW+1)'(fill_r);
  assign wr_slot  = (wr_sum >= (NW+1)'(WINDOW)) ? AW'(wr_sum - (NW+1)'(WINDOW))
                                                : AW'(wr_sum);
  assign last_idx = NFULL - NW'(1);

  // Percentile index floor(n*q/100) by reciprocal multiply
  always_comb begin
    case (cmd.sel)
      2'd0:    mq = M50;
      2'd1:    mq = M95;
      default: mq = M99;
    endcase
    prod    = PW'(fill_r) * PW'(mq);
    pct_idx = AW'(prod >> KW);
  end

  assign sts.full      = had_full_r;
  assign sts.rm_hit    = (rd_r == victim_r);
  assign sts.rm_end    = (idx_r == last_idx);
  assign sts.ins_place = (idx_r == '0) || !(rd_r > lat_r);

  // Ring memory: read victim at load, write new value at load
  always_ff @(posedge clk) begin
    if (cmd.op == swlp_pkg::OP_LOAD) begin
      victim_r <= ring_mem[full_r ? oldest_r : wr_slot];
      ring_mem[full_r ? oldest_r : wr_slot] <= lat_in;
    end
  end

  // Sorted memory: single port, one registered read or one write per cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      swlp_pkg::OP_RM_RD:  rd_r <= sort_mem[AW'(idx_r)];
      swlp_pkg::OP_SH_RD:  rd_r <= sort_mem[AW'(idx_r + NW'(1))];
      swlp_pkg::OP_SH_WR:  sort_mem[AW'(idx_r)] <= rd_r;
      swlp_pkg::OP_INS_RD: if (idx_r != '0) rd_r <= sort_mem[AW'(idx_r - NW'(1))];
      swlp_pkg::OP_INS_STEP: begin
        if (idx_r == '0 || !(rd_r > lat_r)) sort_mem[AW'(idx_r)] <= lat_r;
        else sort_mem[AW'(idx_r)] <= rd_r;
      end
      swlp_pkg::OP_PCT_RD: rd_r <= sort_mem[pct_idx];
      default: ;
    endcase
  end

  // Payload registers and index
  always_ff @(posedge clk) begin
    case (cmd.op)
      swlp_pkg::OP_LOAD:     lat_r <= lat_in;
      swlp_pkg::OP_RM_RD:    ;
      // insertion starts at the last slot of the window after this request
      swlp_pkg::OP_INS_INIT: idx_r <= fill_r - NW'(1);
      swlp_pkg::OP_RM_CMP: begin
        if (!(rd_r == victim_r) && !(idx_r == last_idx)) idx_r <= idx_r + NW'(1);
      end
      swlp_pkg::OP_SH_WR:    idx_r <= idx_r + NW'(1);
      swlp_pkg::OP_INS_STEP: if (!(idx_r == '0 || !(rd_r > lat_r))) idx_r <= idx_r - NW'(1);
      swlp_pkg::OP_PCT_LAT: begin
        case (cmd.sel)
          2'd0:    p50_r <= LW'(rd_r);
          2'd1:    p95_r <= LW'(rd_r);
          default: p99_r <= LW'(rd_r);
        endcase
      end
      default: ;
    endcase
    if (cmd.op == swlp_pkg::OP_LOAD) idx_r <= '0;
  end

  // Control state: pointers, fill and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= '0;
      fill_r     <= '0;
      full_r     <= 1'b0;
      had_full_r <= 1'b0;
      req_r      <= '0;
      suc_r      <= '0;
    end else if (cmd.op == swlp_pkg::OP_LOAD) begin
      had_full_r <= full_r;
      if (req_r != CMAX) req_r <= req_r + CW'(1);
      if (in_data.success && suc_r != CMAX) suc_r <= suc_r + CW'(1);
      if (full_r) begin
        oldest_r <= (oldest_r == AW'(WINDOW - 1)) ? '0 : oldest_r + AW'(1);
      end else begin
        fill_r <= fill_r + NW'(1);
        full_r <= (fill_r + NW'(1)) == NFULL;
      end
    end
  end

  assign out_data.median_latency = p50_r;
  assign out_data.p95_value      = p95_r;
  assign out_data.p99_value      = p99_r;
  assign out_data.requests_seen  = req_r;
  assign out_data.successes_seen = suc_r;
  assign out_data.samples_held   = swlp_pkg::HELD_W'(fill_r);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NFULL) else $error("fill overflow");
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    full_r == (fill_r == NFULL)) else $error("full flag mismatch");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == swlp_pkg::OP_PCT_RD) |-> (NW'(pct_idx) < fill_r))
    else $error("percentile index out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == swlp_pkg::OP_NONE && !out_ready) |=> $stable(req_r))
    else $error("counter moved while idle");
`endif

endmodule

/* rtl/core/sliding_window_latency_percentiles_top.sv */
// Top level of the sliding-window latency percentile tracker.
`timescale 1ns / 1ps
// Each accepted request (latency, success) enters a window of the last WINDOW
// latencies held in arrival order and in sorted order; one result follows with
// the 50th, 95th and 99th percentile, both saturating counters and the sample
// count. Items are handled one at a time through a single-port sorted memory:
// a full-window item first searches out and removes the evicted latency by a
// left shift, then every item inserts its latency by a right shift and reads
// the three percentiles in turn; a filling window skips the removal.
// A new request is taken once the previous result has been delivered.
module sliding_window_latency_percentiles_top #(
  parameter int unsigned WINDOW      = swlp_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swlp_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swlp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swlp_pkg::out_res_t out_data
);

  swlp_pkg::dp_cmd_t cmd;
  swlp_pkg::dp_sts_t sts;

  swlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swlp_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
